/* src/qcpd_pkg.sv */
// Shared types and constants for the cascade PD controller and rotor mixer.
package qcpd_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_M0, S_M1, S_M2, S_M3, S_M4,
        S_TERM,
        S_SQ_LOAD,
        S_SQ_IT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        CFG_OUTER_P   = 3'd0,
        CFG_DERIV_G   = 3'd1,
        CFG_INNER_P   = 3'd2,
        CFG_INNER_D   = 3'd3,
        CFG_MIX_T     = 3'd4,
        CFG_MIX_TILT  = 3'd5,
        CFG_MIX_YAW   = 3'd6,
        CFG_UNUSED    = 3'd7
    } t_cfg_idx;

    localparam int AXES = 4;

    localparam logic [31:0] OUTER_P_RST = 32'd262144;
    localparam logic [31:0] DERIV_G_RST = 32'd6488064;

    // 1/101 in Q0.16
    localparam logic signed [32:0] INV101_Q16 = 33'sd649;

    localparam logic signed [31:0] VEL_LO [AXES] = '{
        -32'sd65536, -32'sd655360, -32'sd655360, -32'sd655360
    };
    localparam logic signed [31:0] VEL_HI [AXES] = '{
        32'sd327680, 32'sd655360, 32'sd655360, 32'sd655360
    };

endpackage

/* src/qcpd_in_if.sv */
// Input channel: references and measurements for one control tick.
interface qcpd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ref_height;
    logic signed [31:0] ref_roll;
    logic signed [31:0] ref_pitch;
    logic signed [31:0] ref_yaw;
    logic signed [31:0] meas_height;
    logic signed [31:0] meas_roll;
    logic signed [31:0] meas_pitch;
    logic signed [31:0] meas_yaw;
    logic signed [31:0] meas_climb_rate;
    logic signed [31:0] meas_roll_rate;
    logic signed [31:0] meas_pitch_rate;
    logic signed [31:0] meas_yaw_rate;

    modport source (
        output valid, ref_height, ref_roll, ref_pitch, ref_yaw,
               meas_height, meas_roll, meas_pitch, meas_yaw,
               meas_climb_rate, meas_roll_rate, meas_pitch_rate, meas_yaw_rate,
        input  ready
    );
    modport sink (
        input  valid, ref_height, ref_roll, ref_pitch, ref_yaw,
               meas_height, meas_roll, meas_pitch, meas_yaw,
               meas_climb_rate, meas_roll_rate, meas_pitch_rate, meas_yaw_rate,
        output ready
    );
endinterface

/* src/qcpd_out_if.sv */
// Output channel: four rotor voltages.
interface qcpd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rotor_volt_0;
    logic [31:0] rotor_volt_1;
    logic [31:0] rotor_volt_2;
    logic [31:0] rotor_volt_3;

    modport source (
        output valid, rotor_volt_0, rotor_volt_1, rotor_volt_2, rotor_volt_3,
        input  ready
    );
    modport sink (
        input  valid, rotor_volt_0, rotor_volt_1, rotor_volt_2, rotor_volt_3,
        output ready
    );
endinterface

/* src/quadrotor_cascade_pd_mixer.sv */
// Cascade PD controller with rotor mixer, one shared multiplier and a bit-serial square root.
// Each input word runs the outer and inner PD loops of every axis on the shared multiplier, then
// the mixer, then a restoring square root per rotor term; a rotor term that is clamped skips its root.
// A new input word is taken only in idle, after the previous word has reached the output register.
// The result sits in an output register, so the next word is taken while it waits.
// Synchronous active-low reset clears the loop state, held command and config to defaults.
module quadrotor_cascade_pd_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    qcpd_in_if.sink     i_in,
    qcpd_out_if.source  o_out
);

    qcpd_pkg::t_state r_state, n_state;

    // configuration
    logic [31:0] r_outer_p, r_deriv_g, r_mix_t, r_mix_a, r_mix_w;
    logic [63:0] r_kp_gains, r_kd_gains;

    // captured input word
    logic signed [31:0] r_ref  [qcpd_pkg::AXES];
    logic signed [31:0] r_meas [qcpd_pkg::AXES];
    logic signed [31:0] r_rate [qcpd_pkg::AXES];

    // loop state
    logic signed [31:0] r_ope  [qcpd_pkg::AXES];
    logic signed [31:0] r_odf  [qcpd_pkg::AXES];
    logic signed [31:0] r_ipe  [qcpd_pkg::AXES];
    logic signed [31:0] r_idf  [qcpd_pkg::AXES];
    logic signed [31:0] r_held [qcpd_pkg::AXES];

    // working registers
    logic [1:0]         r_ax;
    logic signed [31:0] r_e, r_d;
    logic signed [65:0] r_acc, r_prod;
    logic signed [49:0] r_mix  [qcpd_pkg::AXES];
    logic signed [51:0] r_term [qcpd_pkg::AXES];

    // square root
    logic [63:0] r_rad;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic [31:0] r_res [qcpd_pkg::AXES];

    // output register
    logic        r_ovalid;
    logic [31:0] r_volt [qcpd_pkg::AXES];

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic               term_special;
    logic [34:0]        rem_sh, trial;
    logic               in_acc;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -68'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // round half up then floor shift
    function automatic logic signed [67:0] rnd16(input logic signed [65:0] x);
        logic signed [67:0] t;
        t = 68'(x) + 68'sd32768;
        return t >>> 16;
    endfunction

    function automatic logic signed [67:0] rnd8(input logic signed [65:0] x);
        logic signed [67:0] t;
        t = 68'(x) + 68'sd128;
        return t >>> 8;
    endfunction

    function automatic logic signed [32:0] uext32(input logic [31:0] x);
        return signed'({1'b0, x});
    endfunction

    function automatic logic signed [32:0] uext16(input logic [15:0] x);
        return signed'({17'b0, x});
    endfunction

    assign in_acc = i_in.valid && i_in.ready;
    assign mul_p  = mul_a * mul_b;

    assign term_special = (r_term[r_ax] <= 52'sd0) ||
                          (r_term[r_ax] >= 52'sh1000000000000);
    assign rem_sh = {r_rem[32:0], r_rad[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qcpd_pkg::S_IDLE:    if (in_acc) n_state = qcpd_pkg::S_P0;
            qcpd_pkg::S_P0:      n_state = qcpd_pkg::S_P1;
            qcpd_pkg::S_P1:      n_state = qcpd_pkg::S_P2;
            qcpd_pkg::S_P2:      n_state = qcpd_pkg::S_P3;
            qcpd_pkg::S_P3:      n_state = qcpd_pkg::S_P4;
            qcpd_pkg::S_P4:      n_state = qcpd_pkg::S_P5;
            qcpd_pkg::S_P5:      n_state = qcpd_pkg::S_P6;
            qcpd_pkg::S_P6:      n_state = qcpd_pkg::S_P7;
            qcpd_pkg::S_P7:      n_state = qcpd_pkg::S_P8;
            qcpd_pkg::S_P8:      n_state = (r_ax == 2'd3) ? qcpd_pkg::S_M0 : qcpd_pkg::S_P0;
            qcpd_pkg::S_M0:      n_state = qcpd_pkg::S_M1;
            qcpd_pkg::S_M1:      n_state = qcpd_pkg::S_M2;
            qcpd_pkg::S_M2:      n_state = qcpd_pkg::S_M3;
            qcpd_pkg::S_M3:      n_state = qcpd_pkg::S_M4;
            qcpd_pkg::S_M4:      n_state = qcpd_pkg::S_TERM;
            qcpd_pkg::S_TERM:    n_state = qcpd_pkg::S_SQ_LOAD;
            qcpd_pkg::S_SQ_LOAD: begin
                if (!term_special)
                    n_state = qcpd_pkg::S_SQ_IT;
                else if (r_ax == 2'd3)
                    n_state = qcpd_pkg::S_OUT;
            end
            qcpd_pkg::S_SQ_IT: begin
                if (r_cnt == 5'd0)
                    n_state = (r_ax == 2'd3) ? qcpd_pkg::S_OUT : qcpd_pkg::S_SQ_LOAD;
            end
            qcpd_pkg::S_OUT:     if (!r_ovalid) n_state = qcpd_pkg::S_IDLE;
            default:             n_state = qcpd_pkg::S_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb begin
        i_in.ready = (r_state == qcpd_pkg::S_IDLE);
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            qcpd_pkg::S_P1: begin
                mul_a = 33'(sat32(68'(r_e) - 68'(r_ope[r_ax])));
                mul_b = uext32(r_deriv_g);
            end
            qcpd_pkg::S_P2: begin
                mul_a = 33'(r_odf[r_ax]);
                mul_b = qcpd_pkg::INV101_Q16;
            end
            qcpd_pkg::S_P3: begin
                mul_a = 33'(r_e);
                mul_b = uext32(r_outer_p);
            end
            qcpd_pkg::S_P5: begin
                mul_a = 33'(sat32(68'(r_e) - 68'(r_ipe[r_ax])));
                mul_b = uext16(r_kd_gains[16*r_ax +: 16]);
            end
            qcpd_pkg::S_P6: begin
                mul_a = 33'(r_idf[r_ax]);
                mul_b = qcpd_pkg::INV101_Q16;
            end
            qcpd_pkg::S_P7: begin
                mul_a = 33'(r_e);
                mul_b = uext16(r_kp_gains[16*r_ax +: 16]);
            end
            qcpd_pkg::S_M0: begin
                mul_a = 33'(r_held[0]);
                mul_b = uext32(r_mix_t);
            end
            qcpd_pkg::S_M1: begin
                mul_a = 33'(r_held[1]);
                mul_b = uext32(r_mix_a);
            end
            qcpd_pkg::S_M2: begin
                mul_a = 33'(r_held[2]);
                mul_b = uext32(r_mix_a);
            end
            qcpd_pkg::S_M3: begin
                mul_a = 33'(r_held[3]);
                mul_b = uext32(r_mix_w);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= qcpd_pkg::S_IDLE;
        else
            r_state <= n_state;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_p  <= qcpd_pkg::OUTER_P_RST;
            r_deriv_g  <= qcpd_pkg::DERIV_G_RST;
            r_kp_gains <= '0;
            r_kd_gains <= '0;
            r_mix_t    <= '0;
            r_mix_a    <= '0;
            r_mix_w    <= '0;
        end else if (i_cfg_wr_en) begin
            case (qcpd_pkg::t_cfg_idx'(i_cfg_idx))
                qcpd_pkg::CFG_OUTER_P:  r_outer_p  <= i_cfg_data[31:0];
                qcpd_pkg::CFG_DERIV_G:  r_deriv_g  <= i_cfg_data[31:0];
                qcpd_pkg::CFG_INNER_P:  r_kp_gains <= i_cfg_data;
                qcpd_pkg::CFG_INNER_D:  r_kd_gains <= i_cfg_data;
                qcpd_pkg::CFG_MIX_T:    r_mix_t    <= i_cfg_data[31:0];
                qcpd_pkg::CFG_MIX_TILT: r_mix_a    <= i_cfg_data[31:0];
                qcpd_pkg::CFG_MIX_YAW:  r_mix_w    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // loop state and output valid
    always_ff @(posedge i_clk) begin
        logic signed [31:0] v;
        logic signed [31:0] d;
        if (!i_rst_n) begin
            for (int i = 0; i < qcpd_pkg::AXES; i++) begin
                r_ope[i]  <= '0;
                r_odf[i]  <= '0;
                r_ipe[i]  <= '0;
                r_idf[i]  <= '0;
                r_held[i] <= '0;
            end
            r_ovalid <= 1'b0;
            r_ax     <= '0;
        end else begin
            if (r_ovalid && o_out.ready)
                r_ovalid <= 1'b0;
            case (r_state)
                qcpd_pkg::S_IDLE: if (in_acc) r_ax <= '0;
                qcpd_pkg::S_P1:   r_ope[r_ax] <= r_e;
                qcpd_pkg::S_P3: begin
                    d = sat32(68'(r_acc) - rnd16(r_prod));
                    r_odf[r_ax] <= d;
                end
                qcpd_pkg::S_P5:   r_ipe[r_ax] <= r_e;
                qcpd_pkg::S_P7: begin
                    d = sat32(68'(r_acc) - rnd16(r_prod));
                    r_idf[r_ax] <= d;
                end
                qcpd_pkg::S_P8: begin
                    v = sat32(rnd8(r_prod) + 68'(r_d));
                    r_held[r_ax] <= sat32(68'(r_held[r_ax]) + 68'(v));
                    r_ax <= r_ax + 2'd1;
                end
                qcpd_pkg::S_SQ_LOAD: if (term_special) r_ax <= r_ax + 2'd1;
                qcpd_pkg::S_SQ_IT:   if (r_cnt == 5'd0) r_ax <= r_ax + 2'd1;
                qcpd_pkg::S_OUT:     if (!r_ovalid) r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic signed [31:0] v;
        r_prod <= mul_p;
        case (r_state)
            qcpd_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_ref[0]  <= i_in.ref_height;
                    r_ref[1]  <= i_in.ref_roll;
                    r_ref[2]  <= i_in.ref_pitch;
                    r_ref[3]  <= i_in.ref_yaw;
                    r_meas[0] <= i_in.meas_height;
                    r_meas[1] <= i_in.meas_roll;
                    r_meas[2] <= i_in.meas_pitch;
                    r_meas[3] <= i_in.meas_yaw;
                    r_rate[0] <= i_in.meas_climb_rate;
                    r_rate[1] <= i_in.meas_roll_rate;
                    r_rate[2] <= i_in.meas_pitch_rate;
                    r_rate[3] <= i_in.meas_yaw_rate;
                end
            end
            qcpd_pkg::S_P0: r_e <= sat32(68'(r_ref[r_ax]) - 68'(r_meas[r_ax]));
            qcpd_pkg::S_P2: r_acc <= 66'(rnd16(r_prod));
            qcpd_pkg::S_P3: r_d <= sat32(68'(r_acc) - rnd16(r_prod));
            qcpd_pkg::S_P4: begin
                v = sat32(rnd16(r_prod) + 68'(r_d));
                if (v < qcpd_pkg::VEL_LO[r_ax]) v = qcpd_pkg::VEL_LO[r_ax];
                if (v > qcpd_pkg::VEL_HI[r_ax]) v = qcpd_pkg::VEL_HI[r_ax];
                r_e <= sat32(68'(v) - 68'(r_rate[r_ax]));
            end
            qcpd_pkg::S_P6: r_acc <= 66'(rnd8(r_prod));
            qcpd_pkg::S_P7: r_d <= sat32(68'(r_acc) - rnd16(r_prod));
            qcpd_pkg::S_M1: r_mix[0] <= 50'(rnd16(r_prod));
            qcpd_pkg::S_M2: r_mix[1] <= 50'(rnd16(r_prod));
            qcpd_pkg::S_M3: r_mix[2] <= 50'(rnd16(r_prod));
            qcpd_pkg::S_M4: r_mix[3] <= 50'(rnd16(r_prod));
            qcpd_pkg::S_TERM: begin
                // rotor order: h-p-y, h+r+y, h+p-y, h-r+y
                r_term[0] <= 52'(r_mix[0]) - 52'(r_mix[2]) - 52'(r_mix[3]);
                r_term[1] <= 52'(r_mix[0]) + 52'(r_mix[1]) + 52'(r_mix[3]);
                r_term[2] <= 52'(r_mix[0]) + 52'(r_mix[2]) - 52'(r_mix[3]);
                r_term[3] <= 52'(r_mix[0]) - 52'(r_mix[1]) + 52'(r_mix[3]);
            end
            qcpd_pkg::S_SQ_LOAD: begin
                if (r_term[r_ax] <= 52'sd0)
                    r_res[r_ax] <= '0;
                else if (term_special)
                    r_res[r_ax] <= 32'hFFFFFFFF;
                r_rad  <= {r_term[r_ax][47:0], 16'b0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 5'd31;
            end
            qcpd_pkg::S_SQ_IT: begin
                // one root bit per cycle, restoring
                r_rad <= {r_rad[61:0], 2'b00};
                r_cnt <= r_cnt - 5'd1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[30:0], 1'b1};
                    if (r_cnt == 5'd0) r_res[r_ax] <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[30:0], 1'b0};
                    if (r_cnt == 5'd0) r_res[r_ax] <= {r_root[30:0], 1'b0};
                end
            end
            qcpd_pkg::S_OUT: begin
                if (!r_ovalid) begin
                    for (int i = 0; i < qcpd_pkg::AXES; i++)
                        r_volt[i] <= r_res[i];
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.rotor_volt_0 = r_volt[0];
    assign o_out.rotor_volt_1 = r_volt[1];
    assign o_out.rotor_volt_2 = r_volt[2];
    assign o_out.rotor_volt_3 = r_volt[3];

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == qcpd_pkg::S_IDLE)
        else $error("input ready outside idle");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == qcpd_pkg::S_P0)
        else $error("accepted word did not start the sequence");

    a_sqrt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == qcpd_pkg::S_SQ_IT |-> !term_special)
        else $error("root iteration on a clamped rotor term");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qcpd_pkg::S_OUT && !r_ovalid) |=> r_ovalid)
        else $error("finished word not presented");

endmodule

/* sim/quadrotor_cascade_pd_mixer_tb.sv */
// Self-checking testbench for the cascade PD controller and rotor mixer.
module quadrotor_cascade_pd_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 200;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [31:0] refs  [4];
        logic signed [31:0] pos   [4];
        logic signed [31:0] rates [4];
    } t_tick;

    typedef struct {
        logic [31:0] volt [4];
    } t_volts;

    typedef struct {
        logic        has_exp;
        t_tick       tick;
        logic [31:0] volt;   // expected on all four rotors when has_exp
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    qcpd_in_if  in_ch ();
    qcpd_out_if out_ch ();

    quadrotor_cascade_pd_mixer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // predictor state and configuration
    logic [31:0] kp_outer, deriv_gain, mix_t, mix_a, mix_y;
    logic [63:0] kp_inner, kd_inner;
    logic signed [31:0] o_prev [4], o_filt [4], i_prev [4], i_filt [4], held [4];

    t_volts volts_due [$];
    int     errors;
    int     cycles;
    logic   calm;       // no idling in the last stretch
    logic   hold_off;   // long receiver stall

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint rshift_rnd(longint x, int sh);
        longint v;
        v = x + (64'sd1 <<< (sh - 1));
        return v >>> sh;
    endfunction

    function automatic logic [31:0] root_volt(longint term);
        logic [63:0] v, res, bit_w;
        if (term <= 0) return 32'd0;
        if (term >= (64'sd1 <<< 48)) return 32'hFFFF_FFFF;
        v = 64'(term) << 16;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res[31:0];
    endfunction

    function automatic void predictor_reset();
        kp_outer = qcpd_pkg::OUTER_P_RST;
        deriv_gain = qcpd_pkg::DERIV_G_RST;
        kp_inner = '0;
        kd_inner = '0;
        mix_t = '0;
        mix_a = '0;
        mix_y = '0;
        for (int i = 0; i < 4; i++) begin
            o_prev[i] = 0; o_filt[i] = 0; i_prev[i] = 0; i_filt[i] = 0; held[i] = 0;
        end
    endfunction

    function automatic t_volts control_tick(t_tick t);
        longint e, de, d, v, e2, de2, d2, u, kp, kd, h, r, p, y;
        longint terms [4];
        t_volts res;
        for (int i = 0; i < 4; i++) begin
            e = sat32(longint'(t.refs[i]) - longint'(t.pos[i]));
            de = sat32(e - longint'(o_prev[i]));
            d = rshift_rnd(de * longint'({32'd0, deriv_gain}), 16)
                - rshift_rnd(longint'(o_filt[i]) * 649, 16);
            d = sat32(d);
            o_filt[i] = d[31:0];
            o_prev[i] = e[31:0];
            v = sat32(rshift_rnd(e * longint'({32'd0, kp_outer}), 16) + d);
            if (v < longint'(qcpd_pkg::VEL_LO[i])) v = qcpd_pkg::VEL_LO[i];
            if (v > longint'(qcpd_pkg::VEL_HI[i])) v = qcpd_pkg::VEL_HI[i];
            kp = longint'({48'd0, kp_inner[16*i +: 16]});
            kd = longint'({48'd0, kd_inner[16*i +: 16]});
            e2 = sat32(v - longint'(t.rates[i]));
            de2 = sat32(e2 - longint'(i_prev[i]));
            d2 = sat32(rshift_rnd(de2 * kd, 8) - rshift_rnd(longint'(i_filt[i]) * 649, 16));
            i_filt[i] = d2[31:0];
            i_prev[i] = e2[31:0];
            u = sat32(rshift_rnd(e2 * kp, 8) + d2);
            u = sat32(longint'(held[i]) + u);
            held[i] = u[31:0];
        end
        h = rshift_rnd(longint'({32'd0, mix_t}) * longint'(held[0]), 16);
        r = rshift_rnd(longint'({32'd0, mix_a}) * longint'(held[1]), 16);
        p = rshift_rnd(longint'({32'd0, mix_a}) * longint'(held[2]), 16);
        y = rshift_rnd(longint'({32'd0, mix_y}) * longint'(held[3]), 16);
        terms[0] = h - p - y;
        terms[1] = h + r + y;
        terms[2] = h + p - y;
        terms[3] = h - r + y;
        for (int i = 0; i < 4; i++) res.volt[i] = root_volt(terms[i]);
        return res;
    endfunction

    task automatic cfg_write(qcpd_pkg::t_cfg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            qcpd_pkg::CFG_OUTER_P:  kp_outer = val[31:0];
            qcpd_pkg::CFG_DERIV_G:  deriv_gain = val[31:0];
            qcpd_pkg::CFG_INNER_P:  kp_inner = val;
            qcpd_pkg::CFG_INNER_D:  kd_inner = val;
            qcpd_pkg::CFG_MIX_T:    mix_t = val[31:0];
            qcpd_pkg::CFG_MIX_TILT: mix_a = val[31:0];
            qcpd_pkg::CFG_MIX_YAW:  mix_y = val[31:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (volts_due.size() != 0) @(posedge i_clk);
        while (waited < LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // sender: drive at falling edge, accept at rising edge
    task automatic send_tick(t_tick t, logic has_exp, logic [31:0] exp_volt);
        t_volts pv;
        if (!calm && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.ref_height = t.refs[0];  in_ch.ref_roll = t.refs[1];
        in_ch.ref_pitch = t.refs[2];   in_ch.ref_yaw = t.refs[3];
        in_ch.meas_height = t.pos[0];  in_ch.meas_roll = t.pos[1];
        in_ch.meas_pitch = t.pos[2];   in_ch.meas_yaw = t.pos[3];
        in_ch.meas_climb_rate = t.rates[0]; in_ch.meas_roll_rate = t.rates[1];
        in_ch.meas_pitch_rate = t.rates[2]; in_ch.meas_yaw_rate = t.rates[3];
        do @(posedge i_clk); while (!in_ch.ready);
        pv = control_tick(t);
        if (has_exp) begin
            for (int i = 0; i < 4; i++) pv.volt[i] = exp_volt;
        end
        volts_due.push_back(pv);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // receiver with random stalls
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) out_ch.ready = 1'b0;
            else if (!calm && $urandom_range(0, 4) == 0) out_ch.ready = 1'b0;
            else out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_volts want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (volts_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word at cycle %0d", cycles);
            end else begin
                logic [31:0] got [4];
                want = volts_due.pop_front();
                got[0] = out_ch.rotor_volt_0; got[1] = out_ch.rotor_volt_1;
                got[2] = out_ch.rotor_volt_2; got[3] = out_ch.rotor_volt_3;
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want.volt[i]) begin
                        errors++;
                        if (errors <= 10)
                            $display("rotor %0d: expected %h got %h", i, want.volt[i], got[i]);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] rand_field(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1310720)) - 655360);
            default: return 32'($signed($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    function automatic t_tick rand_tick();
        t_tick t;
        int mode;
        mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        for (int i = 0; i < 4; i++) begin
            t.refs[i] = rand_field(mode);
            t.pos[i] = rand_field(mode);
            t.rates[i] = rand_field(mode);
        end
        return t;
    endfunction

    function automatic t_tick flat_tick(logic [31:0] r, logic [31:0] m, logic [31:0] rt);
        t_tick t;
        for (int i = 0; i < 4; i++) begin
            t.refs[i] = r; t.pos[i] = m; t.rates[i] = rt;
        end
        return t;
    endfunction

    initial begin
        t_row rows [$];
        t_row row;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = qcpd_pkg::CFG_OUTER_P;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        {in_ch.ref_height, in_ch.ref_roll, in_ch.ref_pitch, in_ch.ref_yaw} = '0;
        {in_ch.meas_height, in_ch.meas_roll, in_ch.meas_pitch, in_ch.meas_yaw} = '0;
        {in_ch.meas_climb_rate, in_ch.meas_roll_rate} = '0;
        {in_ch.meas_pitch_rate, in_ch.meas_yaw_rate} = '0;
        predictor_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset the mixer coefficients are zero, so every rotor reads zero
        row.has_exp = 1'b1; row.volt = 32'd0;
        row.tick = flat_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000); rows.push_back(row);
        row.tick = flat_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF); rows.push_back(row);
        row.tick = flat_tick(32'd0, 32'd0, 32'd0); rows.push_back(row);
        foreach (rows[k]) send_tick(rows[k].tick, rows[k].has_exp, rows[k].volt);
        drain();

        // extremes of gains and coefficients, errors that saturate, rotors clamped and capped
        cfg_write(qcpd_pkg::CFG_OUTER_P, 64'hFFFF_FFFF);
        cfg_write(qcpd_pkg::CFG_DERIV_G, 64'hFFFF_FFFF);
        cfg_write(qcpd_pkg::CFG_INNER_P, '1);
        cfg_write(qcpd_pkg::CFG_INNER_D, '1);
        cfg_write(qcpd_pkg::CFG_MIX_T, 64'hFFFF_FFFF);
        cfg_write(qcpd_pkg::CFG_MIX_TILT, 64'hFFFF_FFFF);
        cfg_write(qcpd_pkg::CFG_MIX_YAW, 64'hFFFF_FFFF);
        cfg_write(qcpd_pkg::CFG_UNUSED, '1);
        rows.delete();
        row.has_exp = 1'b0;
        row.tick = flat_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000); rows.push_back(row);
        row.tick = flat_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF); rows.push_back(row);
        row.tick = flat_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000); rows.push_back(row);
        row.tick = flat_tick(32'h0001_0000, 32'd0, 32'd0); rows.push_back(row);
        row.tick = flat_tick(32'hFFFF_0000, 32'd0, 32'h0000_8000); rows.push_back(row);
        row.tick = flat_tick(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555); rows.push_back(row);
        row.tick = flat_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA); rows.push_back(row);
        foreach (rows[k]) send_tick(rows[k].tick, rows[k].has_exp, rows[k].volt);
        drain();

        // several random settings, extremes among them
        for (int ph = 0; ph < 5; ph++) begin
            cfg_write(qcpd_pkg::CFG_OUTER_P,
                      ph == 0 ? 64'd0 : 64'($urandom_range(0, 524288)));
            cfg_write(qcpd_pkg::CFG_DERIV_G,
                      ph == 0 ? 64'd0 : 64'($urandom_range(0, 8000000)));
            cfg_write(qcpd_pkg::CFG_INNER_P,
                      {$urandom(), $urandom()} & 64'h03FF_03FF_03FF_03FF);
            cfg_write(qcpd_pkg::CFG_INNER_D, ph == 1 ? '1 : {$urandom(), $urandom()});
            cfg_write(qcpd_pkg::CFG_MIX_T, 64'($urandom_range(0, 262144)));
            cfg_write(qcpd_pkg::CFG_MIX_TILT,
                      ph == 2 ? 64'hFFFF_FFFF : 64'($urandom_range(0, 131072)));
            cfg_write(qcpd_pkg::CFG_MIX_YAW, 64'($urandom()));
            if (ph == 4) calm = 1'b1;
            for (int n = 0; n < 98; n++) begin
                if (ph == 3 && n == 10) begin
                    // receiver holds off while ticks keep coming
                    fork
                        begin
                            int c;
                            hold_off = 1'b1;
                            c = 0;
                            while (c < 800) begin
                                @(posedge i_clk);
                                c++;
                            end
                            hold_off = 1'b0;
                        end
                    join_none
                end
                send_tick(rand_tick(), 1'b0, '0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* quadrotor_cascade_pd_mixer.f */
src/qcpd_pkg.sv
src/qcpd_in_if.sv
src/qcpd_out_if.sv
src/quadrotor_cascade_pd_mixer.sv
sim/quadrotor_cascade_pd_mixer_tb.sv
